[rtl/ptt_pkg.sv]
// Package for the periodic task timer and thread picker.
// Holds the command codes, field widths and the control struct for the thread cells.
// No dependencies.
`default_nettype none

package ptt_pkg;

    localparam int SLOTS_DEF    = 4;
    localparam int THREADS_DEF  = 3;
    localparam int CMD_W        = 2;
    localparam int SLEEP_W      = 32;
    localparam int PERIOD_W     = 16;
    localparam int MASK_W       = 4;
    localparam int THREAD_OUT_W = 2;
    localparam int CFG_REGS     = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_SLEEP  = 2'd1,
        CMD_SWITCH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic               tick;
        logic               pass;
        logic [SLEEP_W-1:0] sleep_val;
    } thr_ctl_t;

endpackage

`default_nettype wire

[rtl/ptt_slot_cell.sv]
// One periodic slot: period register and elapsed counter, fires on tick.
// Depends on ptt_pkg.
`default_nettype none

module ptt_slot_cell (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         tick,
    input  wire logic                         wr_en,
    input  wire logic [ptt_pkg::PERIOD_W-1:0] wr_data,
    output logic                              fire
);
    import ptt_pkg::*;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic                enabled;

    assign enabled = (period_reg != '0);
    assign fire    = tick && enabled && (elapsed_reg >= period_reg - 1'b1);

    always_comb begin
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        if (wr_en) begin
            period_next  = wr_data;
            elapsed_next = '0;
        end else if (tick) begin
            if (!enabled || fire) begin
                elapsed_next = '0;
            end else begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= '0;
            elapsed_reg <= '0;
        end else begin
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ptt_thread_cell.sv]
// One thread of the ring: sleep counter and a search token handed to the next cell.
// Depends on ptt_pkg.
`default_nettype none

module ptt_thread_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ptt_pkg::thr_ctl_t ctl,
    input  wire logic              load,
    input  wire logic              tok_in,
    output logic                   tok_out,
    output logic                   claim
);
    import ptt_pkg::*;

    logic [SLEEP_W-1:0] sleep_reg, sleep_next;
    logic               tok_reg;
    logic               awake;

    assign awake   = (sleep_reg == '0);
    assign claim   = tok_reg && awake;
    // token moves on only past a sleeping thread
    assign tok_out = tok_reg && !awake && ctl.pass;

    always_comb begin
        sleep_next = sleep_reg;
        if (load) begin
            sleep_next = ctl.sleep_val;
        end else if (ctl.tick && !awake) begin
            sleep_next = sleep_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleep_reg <= '0;
            tok_reg   <= 1'b0;
        end else begin
            sleep_reg <= sleep_next;
            tok_reg   <= tok_in;
        end
    end

endmodule

`default_nettype wire

[rtl/periodic_task_timer_and_thread_picker.sv]
// Top level: periodic slot timers and round-robin thread picker.
// Depends on ptt_pkg, ptt_slot_cell, ptt_thread_cell.
//
// Usage:
//   Input items: s_tuser carries the command (tick, sleep, switch), s_tdata the
//   sleep length in ticks. Each accepted item gives exactly one result item on
//   the m_ channel with the fired slot mask, the running thread and the
//   all-asleep flag.
//   Tick, sleep and the unused code finish in the accept cycle: the result is
//   valid in the cycle after acceptance, and a new item can be taken every
//   cycle while the output is free. Switch hands a search token around the
//   ring of thread cells, one cell per cycle, starting after the running
//   thread; s_tready stays low until the result is loaded.
//   Period registers are written through cfg_we/cfg_idx/cfg_data; a write
//   restarts that slot. Write them only while the block is idle.
//   Reset (aresetn low, synchronous) clears periods, counters and the output
//   register and selects thread 0.
//   When the receiver stalls, the result holds in the output register and no
//   new item is accepted until it is taken.
`default_nettype none

module periodic_task_timer_and_thread_picker #(
    parameter int PERIODIC_SLOTS = ptt_pkg::SLOTS_DEF,
    parameter int THREADS        = ptt_pkg::THREADS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] sleep_ticks
    input  wire logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  wire logic [ptt_pkg::CMD_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] fired_mask, [5:4] current_thread, [6] all_asleep, [7] zero
    output logic [ptt_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [ptt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [ptt_pkg::PERIOD_W-1:0]  cfg_data
);
    import ptt_pkg::*;

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int MS = (PERIODIC_SLOTS < MASK_W) ? PERIODIC_SLOTS : MASK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [TW-1:0]           run_reg, run_next;
    logic [TW-1:0]           step_reg, step_next;
    logic                    asleep_reg, asleep_next;
    logic                    m_valid_reg, m_valid_next;
    logic [MASK_W-1:0]       m_fired_reg, m_fired_next;
    logic [THREAD_OUT_W-1:0] m_thread_reg, m_thread_next;
    logic                    m_asleep_reg, m_asleep_next;

    cmd_t                    cmd;
    logic                    accept;
    logic                    out_free;
    logic [TW-1:0]           next_thr;
    logic [TW-1:0]           claim_idx;
    logic [PERIODIC_SLOTS-1:0] fire;
    logic [MASK_W-1:0]       fire_mask;
    logic [THREADS-1:0]      tok_out;
    logic [THREADS-1:0]      claim;
    thr_ctl_t                thr_ctl;

    assign cmd      = cmd_t'(s_tuser);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign next_thr = (run_reg == TW'(THREADS - 1)) ? '0 : run_reg + 1'b1;

    assign thr_ctl.tick      = accept && (cmd == CMD_TICK);
    assign thr_ctl.pass      = (state_reg == ST_SEARCH) && (step_reg != TW'(THREADS - 1));
    assign thr_ctl.sleep_val = s_tdata;

    genvar gs;
    generate
        for (gs = 0; gs < PERIODIC_SLOTS; gs++) begin : g_slot
            ptt_slot_cell u_slot (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tick    (thr_ctl.tick),
                .wr_en   (cfg_we && (gs < CFG_REGS) && (cfg_idx == CFG_IDX_W'(gs))),
                .wr_data (cfg_data),
                .fire    (fire[gs])
            );
        end
    endgenerate

    always_comb begin
        fire_mask = '0;
        for (int i = 0; i < MS; i++) begin
            fire_mask[i] = fire[i];
        end
    end

    genvar gt;
    generate
        for (gt = 0; gt < THREADS; gt++) begin : g_thr
            ptt_thread_cell u_thr (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (thr_ctl),
                .load    (accept && (cmd == CMD_SLEEP) && (run_reg == TW'(gt))),
                .tok_in  (tok_out[(gt + THREADS - 1) % THREADS] ||
                          (accept && (cmd == CMD_SWITCH) && (next_thr == TW'(gt)))),
                .tok_out (tok_out[gt]),
                .claim   (claim[gt])
            );
        end
    endgenerate

    always_comb begin
        claim_idx = '0;
        for (int i = 0; i < THREADS; i++) begin
            if (claim[i]) begin
                claim_idx = claim_idx | TW'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        run_next      = run_reg;
        step_next     = step_reg;
        asleep_next   = asleep_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_fired_next  = m_fired_reg;
        m_thread_next = m_thread_reg;
        m_asleep_next = m_asleep_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (cmd == CMD_SWITCH) begin
                        state_next = ST_SEARCH;
                        step_next  = '0;
                    end else begin
                        m_valid_next  = 1'b1;
                        m_fired_next  = (cmd == CMD_TICK) ? fire_mask : '0;
                        m_thread_next = THREAD_OUT_W'(run_reg);
                        m_asleep_next = 1'b0;
                    end
                end
            end
            ST_SEARCH: begin
                if (|claim) begin
                    run_next    = claim_idx;
                    asleep_next = 1'b0;
                    state_next  = ST_DONE;
                end else if (step_reg == TW'(THREADS - 1)) begin
                    asleep_next = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_fired_next  = '0;
                    m_thread_next = THREAD_OUT_W'(run_reg);
                    m_asleep_next = asleep_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            run_reg      <= '0;
            step_reg     <= '0;
            asleep_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_fired_reg  <= '0;
            m_thread_reg <= '0;
            m_asleep_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            step_reg     <= step_next;
            asleep_reg   <= asleep_next;
            m_valid_reg  <= m_valid_next;
            m_fired_reg  <= m_fired_next;
            m_thread_reg <= m_thread_next;
            m_asleep_reg <= m_asleep_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_asleep_reg, m_thread_reg, m_fired_reg};

endmodule

`default_nettype wire

[rtl/ptt_checker.sv]
// Port-level checks for the periodic task timer and thread picker, with its bind.
// Depends on ptt_pkg and periodic_task_timer_and_thread_picker.
`default_nettype none

module ptt_checker #(
    parameter int THREADS = ptt_pkg::THREADS_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ptt_pkg::M_TDATA_W-1:0] m_tdata
);
    import ptt_pkg::*;

    a_thread_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (THREADS > 3) || (m_tdata[5:4] < 2'(THREADS)))
        else $error("current_thread out of range");

    a_asleep_no_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> (m_tdata[3:0] == 4'd0))
        else $error("all_asleep with fired slots");

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready || m_tvalid)
        else $error("item accepted without result");

endmodule

bind periodic_task_timer_and_thread_picker ptt_checker #(.THREADS(THREADS)) u_ptt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/ptt_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for periodic_task_timer_and_thread_picker: watches the config port
// and both stream channels, predicts each result item and compares it field by field.
// Depends on ptt_pkg.

module ptt_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [31:0] sleep_ticks
    input  logic [ptt_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [ptt_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] fired_mask, [5:4] current_thread, [6] all_asleep, [7] zero
    input  logic [ptt_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [ptt_pkg::PERIOD_W-1:0]  cfg_data,
    output int                            fail_count,
    output int                            outstanding
);
    import ptt_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int NTHR  = THREADS_DEF;

    typedef struct packed {
        logic [MASK_W-1:0]       fired;
        logic [THREAD_OUT_W-1:0] thread;
        logic                    asleep;
    } status_t;

    logic [PERIOD_W-1:0] period    [NSLOT];
    logic [PERIOD_W-1:0] elapsed   [NSLOT];
    logic [SLEEP_W-1:0]  sleep_cnt [NTHR];
    int unsigned         running;
    status_t             status_q  [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic status_t step_timer_and_picker(cmd_t cmd, logic [SLEEP_W-1:0] ticks);
        status_t     r;
        int unsigned cand;
        bit          found;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (period[i] == '0) begin
                        elapsed[i] = '0;
                    end else if (elapsed[i] >= period[i] - 1'b1) begin
                        elapsed[i] = '0;
                        r.fired[i] = 1'b1;
                    end else begin
                        elapsed[i] = elapsed[i] + 1'b1;
                    end
                end
                for (int t = 0; t < NTHR; t++)
                    if (sleep_cnt[t] != '0) sleep_cnt[t] = sleep_cnt[t] - 1'b1;
            end
            CMD_SLEEP: sleep_cnt[running] = ticks;
            CMD_SWITCH: begin
                cand  = running;
                found = 1'b0;
                for (int k = 0; k < NTHR; k++) begin
                    if (!found) begin
                        cand = (cand + 1 >= NTHR) ? 0 : cand + 1;
                        if (sleep_cnt[cand] == '0) begin
                            running = cand;
                            found   = 1'b1;
                        end
                    end
                end
                r.asleep = !found;
            end
            default: ;
        endcase
        r.thread = running[THREAD_OUT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        status_t want;
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                period[i]  = '0;
                elapsed[i] = '0;
            end
            for (int t = 0; t < NTHR; t++) sleep_cnt[t] = '0;
            running = 0;
            status_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $error("result item with none expected: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("fired_mask", want.fired, m_tdata[3:0]);
                    check_field("current_thread", want.thread, m_tdata[5:4]);
                    check_field("all_asleep", want.asleep, m_tdata[6]);
                    check_field("pad", 0, m_tdata[7]);
                end
            end
            if (cfg_we && cfg_idx < NSLOT) begin
                period[cfg_idx]  = cfg_data;
                elapsed[cfg_idx] = '0;
            end
            if (s_tvalid && s_tready)
                status_q.push_back(step_timer_and_picker(cmd_t'(s_tuser), s_tdata));
        end
        outstanding <= status_q.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench top for periodic_task_timer_and_thread_picker: clock, reset, period writes
// and command stimulus under several idle/stall mixes; prints the verdict.
// Depends on ptt_pkg, the RTL and ptt_result_checker.

module tb;
    import ptt_pkg::*;

    typedef logic [PERIOD_W-1:0] period_set_t [CFG_REGS];

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [PERIOD_W-1:0]  cfg_data = '0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   outstanding;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;

    always #5 aclk = ~aclk;

    periodic_task_timer_and_thread_picker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    ptt_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_cmd(cmd_t cmd, logic [S_TDATA_W-1:0] ticks);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ticks;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd != CMD_NONE) items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (THREADS_DEF + 2) @(posedge aclk);
    endtask

    task automatic set_periods(period_set_t p);
        for (int i = 0; i < CFG_REGS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= p[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_episode();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            repeat ($urandom_range(1, 4)) send_cmd(CMD_TICK, $urandom);
        end else if (pick < 65) begin
            send_cmd(CMD_SLEEP, $urandom_range(0, 8));
            send_cmd(CMD_SWITCH, $urandom);
        end else if (pick < 82) begin
            send_cmd(CMD_SWITCH, $urandom);
        end else if (pick < 90) begin
            // wide sleep value, then overwritten so the thread is not lost for the run
            send_cmd(CMD_SLEEP, $urandom);
            send_cmd(CMD_SLEEP, $urandom_range(0, 6));
        end else if (pick < 95) begin
            send_cmd(CMD_NONE, $urandom);
        end else begin
            send_cmd(CMD_SLEEP, $urandom_range(0, 6));
        end
    endtask

    initial begin
        period_set_t phase_periods [4];
        int          idle_mix [4][2];
        int          target;

        phase_periods[0] = '{16'd1, 16'd2, 16'd3, 16'd0};
        phase_periods[1] = '{16'hFFFF, 16'd1, 16'd5, 16'd7};
        phase_periods[2] = '{16'd4, 16'd0, 16'hFFFF, 16'd2};
        for (int i = 0; i < CFG_REGS; i++) phase_periods[3][i] = PERIOD_W'($urandom_range(0, 9));
        idle_mix = '{'{0, 0}, '{58, 0}, '{0, 58}, '{30, 30}};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all slots disabled after reset
        send_cmd(CMD_TICK, '0);
        send_cmd(CMD_NONE, 32'hFFFF_FFFF);
        send_cmd(CMD_SWITCH, '0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_periods(phase_periods[ph]);
            tx_idle_pct  = idle_mix[ph][0];
            rx_stall_pct = idle_mix[ph][1];
            if (ph == 0) begin
                repeat (3) send_cmd(CMD_TICK, '0);
                // put every thread to sleep, running one with the longest count
                send_cmd(CMD_SLEEP, 32'd2);
                send_cmd(CMD_SWITCH, '0);
                send_cmd(CMD_SLEEP, 32'd2);
                send_cmd(CMD_SWITCH, '0);
                send_cmd(CMD_SLEEP, 32'hFFFF_FFFF);
                send_cmd(CMD_SWITCH, '0);
                send_cmd(CMD_SLEEP, 32'd0);
                // others still asleep: running thread found last
                send_cmd(CMD_TICK, 32'hFFFF_FFFF);
                send_cmd(CMD_SWITCH, '0);
                send_cmd(CMD_TICK, '0);
                send_cmd(CMD_SWITCH, 32'hFFFF_FFFF);
            end
            target = items_sent + 113;
            while (items_sent < target) random_episode();
            drain();
        end

        if (fail_count == 0) begin
            $display("** periodic_task_timer_and_thread_picker: PASSED **");
        end else begin
            $display("** periodic_task_timer_and_thread_picker: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** periodic_task_timer_and_thread_picker: FAILED **");
        $finish;
    end

endmodule

[periodic_task_timer_and_thread_picker.f]
rtl/ptt_pkg.sv
rtl/ptt_slot_cell.sv
rtl/ptt_thread_cell.sv
rtl/periodic_task_timer_and_thread_picker.sv
rtl/ptt_checker.sv
test/ptt_result_checker.sv
test/tb.sv
